// ===== rtl/npci_pkg.sv =====
// Shared types, palette and square function for the nearest palette colour index block.
package npci_pkg;

	// Widths fixed by the colour format.
	localparam int CHAN_W  = 8;
	localparam int INDEX_W = 8;
	localparam int DIST_W  = 18;
	localparam int TABLE_SIZE = 256;

	// Larger than any real distance, so the first searched entry always wins.
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// One link of the compare chain: a request in flight and its best match so far.
	typedef struct packed {
		logic                        valid;
		logic                        empty;
		logic [3*CHAN_W-1:0]         chan;
		logic [INDEX_W-1:0]          best_idx;
		logic [DIST_W-1:0]           best_dist;
	} npci_link_t;

	// Square of one byte difference, kept to its low 16 bits.
	function automatic logic [2*CHAN_W-1:0] sq_entry(input int unsigned v);
		int unsigned p;
		p = v * v;
		return p[2*CHAN_W-1:0];
	endfunction

	// Fixed default palette; byte 3 of each entry takes no part in the distance.
	localparam logic [31:0] PALETTE [TABLE_SIZE] = '{
		32'h00000000, 32'hffffffff, 32'hffccffff, 32'hff99ffff, 32'hff66ffff, 32'hff33ffff,
		32'hff00ffff, 32'hffffccff, 32'hffccccff, 32'hff99ccff, 32'hff66ccff, 32'hff33ccff,
		32'hff00ccff, 32'hffff99ff, 32'hffcc99ff, 32'hff9999ff, 32'hff6699ff, 32'hff3399ff,
		32'hff0099ff, 32'hffff66ff, 32'hffcc66ff, 32'hff9966ff, 32'hff6666ff, 32'hff3366ff,
		32'hff0066ff, 32'hffff33ff, 32'hffcc33ff, 32'hff9933ff, 32'hff6633ff, 32'hff3333ff,
		32'hff0033ff, 32'hffff00ff, 32'hffcc00ff, 32'hff9900ff, 32'hff6600ff, 32'hff3300ff,
		32'hff0000ff, 32'hffffffcc, 32'hffccffcc, 32'hff99ffcc, 32'hff66ffcc, 32'hff33ffcc,
		32'hff00ffcc, 32'hffffcccc, 32'hffcccccc, 32'hff99cccc, 32'hff66cccc, 32'hff33cccc,
		32'hff00cccc, 32'hffff99cc, 32'hffcc99cc, 32'hff9999cc, 32'hff6699cc, 32'hff3399cc,
		32'hff0099cc, 32'hffff66cc, 32'hffcc66cc, 32'hff9966cc, 32'hff6666cc, 32'hff3366cc,
		32'hff0066cc, 32'hffff33cc, 32'hffcc33cc, 32'hff9933cc, 32'hff6633cc, 32'hff3333cc,
		32'hff0033cc, 32'hffff00cc, 32'hffcc00cc, 32'hff9900cc, 32'hff6600cc, 32'hff3300cc,
		32'hff0000cc, 32'hffffff99, 32'hffccff99, 32'hff99ff99, 32'hff66ff99, 32'hff33ff99,
		32'hff00ff99, 32'hffffcc99, 32'hffcccc99, 32'hff99cc99, 32'hff66cc99, 32'hff33cc99,
		32'hff00cc99, 32'hffff9999, 32'hffcc9999, 32'hff999999, 32'hff669999, 32'hff339999,
		32'hff009999, 32'hffff6699, 32'hffcc6699, 32'hff996699, 32'hff666699, 32'hff336699,
		32'hff006699, 32'hffff3399, 32'hffcc3399, 32'hff993399, 32'hff663399, 32'hff333399,
		32'hff003399, 32'hffff0099, 32'hffcc0099, 32'hff990099, 32'hff660099, 32'hff330099,
		32'hff000099, 32'hffffff66, 32'hffccff66, 32'hff99ff66, 32'hff66ff66, 32'hff33ff66,
		32'hff00ff66, 32'hffffcc66, 32'hffcccc66, 32'hff99cc66, 32'hff66cc66, 32'hff33cc66,
		32'hff00cc66, 32'hffff9966, 32'hffcc9966, 32'hff999966, 32'hff669966, 32'hff339966,
		32'hff009966, 32'hffff6666, 32'hffcc6666, 32'hff996666, 32'hff666666, 32'hff336666,
		32'hff006666, 32'hffff3366, 32'hffcc3366, 32'hff993366, 32'hff663366, 32'hff333366,
		32'hff003366, 32'hffff0066, 32'hffcc0066, 32'hff990066, 32'hff660066, 32'hff330066,
		32'hff000066, 32'hffffff33, 32'hffccff33, 32'hff99ff33, 32'hff66ff33, 32'hff33ff33,
		32'hff00ff33, 32'hffffcc33, 32'hffcccc33, 32'hff99cc33, 32'hff66cc33, 32'hff33cc33,
		32'hff00cc33, 32'hffff9933, 32'hffcc9933, 32'hff999933, 32'hff669933, 32'hff339933,
		32'hff009933, 32'hffff6633, 32'hffcc6633, 32'hff996633, 32'hff666633, 32'hff336633,
		32'hff006633, 32'hffff3333, 32'hffcc3333, 32'hff993333, 32'hff663333, 32'hff333333,
		32'hff003333, 32'hffff0033, 32'hffcc0033, 32'hff990033, 32'hff660033, 32'hff330033,
		32'hff000033, 32'hffffff00, 32'hffccff00, 32'hff99ff00, 32'hff66ff00, 32'hff33ff00,
		32'hff00ff00, 32'hffffcc00, 32'hffcccc00, 32'hff99cc00, 32'hff66cc00, 32'hff33cc00,
		32'hff00cc00, 32'hffff9900, 32'hffcc9900, 32'hff999900, 32'hff669900, 32'hff339900,
		32'hff009900, 32'hffff6600, 32'hffcc6600, 32'hff996600, 32'hff666600, 32'hff336600,
		32'hff006600, 32'hffff3300, 32'hffcc3300, 32'hff993300, 32'hff663300, 32'hff333300,
		32'hff003300, 32'hffff0000, 32'hffcc0000, 32'hff990000, 32'hff660000, 32'hff330000,
		32'hff0000ee, 32'hff0000dd, 32'hff0000bb, 32'hff0000aa, 32'hff000088, 32'hff000077,
		32'hff000055, 32'hff000044, 32'hff000022, 32'hff000011, 32'hff00ee00, 32'hff00dd00,
		32'hff00bb00, 32'hff00aa00, 32'hff008800, 32'hff007700, 32'hff005500, 32'hff004400,
		32'hff002200, 32'hff001100, 32'hffee0000, 32'hffdd0000, 32'hffbb0000, 32'hffaa0000,
		32'hff880000, 32'hff770000, 32'hff550000, 32'hff440000, 32'hff220000, 32'hff110000,
		32'hffeeeeee, 32'hffdddddd, 32'hffbbbbbb, 32'hffaaaaaa, 32'hff888888, 32'hff777777,
		32'hff555555, 32'hff444444, 32'hff222222, 32'hff111111
	};

endpackage

// ===== rtl/npci_cell.sv =====
// One compare cell: holds a palette entry and updates the best match of the passing request.
module npci_cell
	import npci_pkg::*;
#(
	parameter int CELL_INDEX = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  npci_link_t link_in,
	output npci_link_t link_q
);

	localparam logic [31:0]        ENTRY = PALETTE[CELL_INDEX];
	localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(CELL_INDEX);

	logic [CHAN_W-1:0]   diff [3];
	logic [2*CHAN_W-1:0] sq   [3];
	logic [DIST_W-1:0]   cand_dist;
	logic                better;
	npci_link_t          link_d;

	// Absolute channel differences and their squares.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [CHAN_W-1:0] a;
			logic [CHAN_W-1:0] b;
			a = link_in.chan[c*CHAN_W +: CHAN_W];
			b = ENTRY[c*CHAN_W +: CHAN_W];
			diff[c] = (a >= b) ? (a - b) : (b - a);
			sq[c] = sq_entry(int'(diff[c]));
		end
	end

	// Squared distance; only a strictly nearer entry takes over, so lower indices win ties.
	assign cand_dist = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
	assign better = !link_in.empty && (cand_dist < link_in.best_dist);

	always_comb begin
		link_d = link_in;
		if (better) begin
			link_d.best_idx  = MY_INDEX;
			link_d.best_dist = cand_dist;
		end
	end

	// Hand the request on to the next cell whenever the chain moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (advance) begin
			link_q <= link_d;
		end
	end

endmodule

// ===== rtl/nearest_palette_color_index.sv =====
// Top level of the nearest palette colour index block: a chain of compare cells.
//
// Usage: a request carries one packed 32-bit colour on color, handed over with
// color_valid and color_ready. The result, an 8-bit palette index, leaves on
// palette_index with index_valid and index_ready. A colour of zero gives index
// 0; any other colour gives the nearest of palette entries 1 to
// PALETTE_ENTRIES-1 by squared distance over its top three bytes, the lowest
// index winning a tie.
// The request walks a row of PALETTE_ENTRIES-1 registered cells, one palette
// entry per cell, and its result leaves the last cell. The chain moves
// unless a result is held back, so one request is taken and one result given
// per cycle while the receiver keeps up.
// The last cell doubles as the output register. When a result waits and
// index_ready is low the whole chain holds, and color_ready drops with it;
// it rises again as soon as that result is taken.
// Reset clears every valid bit in the chain; nothing else needs clearing.
module nearest_palette_color_index
	import npci_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               color_valid,
	output logic               color_ready,
	input  logic [31:0]        color,
	output logic               index_valid,
	input  logic               index_ready,
	output logic [INDEX_W-1:0] palette_index
);

	localparam int CELLS = PALETTE_ENTRIES - 1;

	npci_link_t chain [PALETTE_ENTRIES];
	logic       advance;

	// The chain moves unless a finished result is held back by the receiver.
	assign advance     = !chain[CELLS].valid || index_ready;
	assign color_ready = advance;

	// Head of the chain: a fresh request with no match yet.
	always_comb begin
		chain[0].valid     = color_valid;
		chain[0].empty     = (color == 32'd0);
		chain[0].chan      = color[31:8];
		chain[0].best_idx  = '0;
		chain[0].best_dist = DIST_MAX;
	end

	// One cell per searched palette entry.
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		npci_cell #(
			.CELL_INDEX(k + 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.link_in(chain[k]),
			.link_q (chain[k+1])
		);
	end

	assign index_valid   = chain[CELLS].valid;
	assign palette_index = chain[CELLS].best_idx;

endmodule

// ===== rtl/npci_checker.sv =====
// Port-level checks for the nearest palette colour index block, bound to its top level.
module npci_checker
	import npci_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input logic               clk,
	input logic               arst_n,
	input logic               color_valid,
	input logic               color_ready,
	input logic [31:0]        color,
	input logic               index_valid,
	input logic               index_ready,
	input logic [INDEX_W-1:0] palette_index
);

	// A waiting request keeps its colour until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && !color_ready |=> color_valid && $stable(color))
		else $error("waiting request changed");

	// A result held back by the receiver keeps its index.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		index_valid && !index_ready |=> index_valid && $stable(palette_index))
		else $error("stalled result changed");

	// The chain takes a request exactly when its last stage is free or being emptied.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		color_ready == (!index_valid || index_ready))
		else $error("request ready does not follow the output stall");

	// A result never names an entry beyond the searched palette.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		index_valid |-> ({1'b0, palette_index} < 9'(PALETTE_ENTRIES)))
		else $error("palette index out of range");

	// While the receiver stalls, no new request enters.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		index_valid && !index_ready |-> !color_ready)
		else $error("request taken while output stalled");

endmodule

bind nearest_palette_color_index npci_checker #(
	.PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npci_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.color_valid  (color_valid),
	.color_ready  (color_ready),
	.color        (color),
	.index_valid  (index_valid),
	.index_ready  (index_ready),
	.palette_index(palette_index)
);
